### rtl/core/fpab_pkg.sv
package fpab_pkg;

    localparam logic [1:0] FMT_RGB565   = 2'd0;
    localparam logic [1:0] FMT_RGBA5551 = 2'd1;
    localparam logic [1:0] FMT_RGBA4444 = 2'd2;
    localparam logic [1:0] FMT_RGBA8888 = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [15:0] ROUND_HALF  = 16'd127;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } fpab_rgba_t;

    typedef struct packed {
        logic mul_en;
        logic div_en;
    } fpab_stage_en_t;

endpackage

### rtl/core/fpab_unpack.sv
module fpab_unpack
    import fpab_pkg::*;
(
    input  logic [1:0]  fmt,
    input  logic [31:0] word,
    output fpab_rgba_t  color
);

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    always_comb
    begin
        case (fmt)
            FMT_RGBA8888:
            begin
                color.r = word[7:0];
                color.g = word[15:8];
                color.b = word[23:16];
                color.a = word[31:24];
            end
            FMT_RGB565:
            begin
                color.r = widen5(word[4:0]);
                color.g = widen6(word[10:5]);
                color.b = widen5(word[15:11]);
                color.a = ALPHA_OPAQUE;
            end
            FMT_RGBA5551:
            begin
                color.r = widen5(word[4:0]);
                color.g = widen5(word[9:5]);
                color.b = widen5(word[14:10]);
                color.a = {8{word[15]}};
            end
            default:
            begin
                color.r = widen4(word[3:0]);
                color.g = widen4(word[7:4]);
                color.b = widen4(word[11:8]);
                color.a = widen4(word[15:12]);
            end
        endcase
    end

endmodule

### rtl/core/fpab_channel_mix.sv
module fpab_channel_mix
    import fpab_pkg::*;
(
    input  logic           clk,
    input  fpab_stage_en_t en,
    input  logic [7:0]     src,
    input  logic [7:0]     dst,
    input  logic [7:0]     alpha,
    output logic [7:0]     mixed
);

    // (src*a + dst*(255-a) + 127) / 255, sum stays below 2^16
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  mixed_reg;
    logic [7:0]  mixed_next;
    logic [7:0]  inv_alpha;
    logic [16:0] div_acc;

    assign inv_alpha = ALPHA_OPAQUE - alpha;
    assign sum_next  = 16'(src * alpha) + 16'(dst * inv_alpha) + ROUND_HALF;

    // exact x/255 for x < 255*256; the sum never exceeds 255*255+127
    assign div_acc    = {1'b0, sum_reg} + {9'd0, sum_reg[15:8]} + 17'd1;
    assign mixed_next = div_acc[15:8];

    always_ff @(posedge clk)
    begin
        if (en.mul_en)
        begin
            sum_reg <= sum_next;
        end
        if (en.div_en)
        begin
            mixed_reg <= mixed_next;
        end
    end

    assign mixed = mixed_reg;

endmodule

### rtl/core/fpab_pack.sv
module fpab_pack
    import fpab_pkg::*;
(
    input  logic [1:0]  fmt,
    input  fpab_rgba_t  color,
    output logic [31:0] word
);

    always_comb
    begin
        case (fmt)
            FMT_RGBA8888:
                word = {color.a, color.b, color.g, color.r};
            FMT_RGB565:
                word = {16'd0, color.b[7:3], color.g[7:2], color.r[7:3]};
            FMT_RGBA5551:
                word = {16'd0, color.a[7], color.b[7:3], color.g[7:3], color.r[7:3]};
            default:
                word = {16'd0, color.a[7:4], color.b[7:4], color.g[7:4], color.r[7:4]};
        endcase
    end

endmodule

### rtl/core/framebuffer_pixel_alpha_blend.sv
// Source-over alpha blender for one framebuffer pixel per clock unless
// stalled. Each pixel transaction carries the destination word, its address
// and an RGBA source color; the blended word leaves with the address, packed
// in the format held in the pixel_mode register. The four register stages
// are unpack, channel multiply-add, divide by 255 and repack; a new pixel can
// enter every cycle, and the input is stalled only when all four stages hold
// pixels and the result is stalled. Pixels with zero source alpha are dropped
// at the entry stage and produce no write. Change pixel_mode only while the
// pipeline is empty.
module framebuffer_pixel_alpha_blend
    import fpab_pkg::*;
#(
    parameter int ADDRESS_BITS = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_data,

    input  logic                    pixel_valid,
    output logic                    pixel_stall,
    input  logic [ADDRESS_BITS-1:0] pixel_address,
    input  logic [31:0]             dest_pixel,
    input  logic [7:0]              src_red,
    input  logic [7:0]              src_green,
    input  logic [7:0]              src_blue,
    input  logic [7:0]              src_alpha,

    output logic                    write_valid,
    input  logic                    write_stall,
    output logic [ADDRESS_BITS-1:0] write_address,
    output logic [31:0]             new_pixel
);

    logic [1:0] pixel_mode_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;
    logic pixel_accept;

    fpab_rgba_t              dst_next;
    fpab_rgba_t              dst_reg;
    fpab_rgba_t              src_reg;
    logic [ADDRESS_BITS-1:0] addr1_reg, addr2_reg, addr3_reg, addr4_reg;
    fpab_rgba_t              mixed;
    logic [31:0]             packed_next;
    logic [31:0]             pixel_reg;
    fpab_stage_en_t          stage_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg <= FMT_RGB565;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pixel_mode_reg <= cfg_data;
        end
    end

    // a stage advances when it is empty or the one ahead moves
    assign r4 = !v4_reg || !write_stall;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;

    assign pixel_stall  = !r1;
    assign pixel_accept = pixel_valid && r1;

    assign stage_en.mul_en = r2;
    assign stage_en.div_en = r3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= pixel_valid && (src_alpha != 8'd0);
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (r4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    fpab_unpack u_unpack (
        .fmt   (pixel_mode_reg),
        .word  (dest_pixel),
        .color (dst_next)
    );

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            dst_reg   <= dst_next;
            src_reg   <= '{r: src_red, g: src_green, b: src_blue, a: src_alpha};
            addr1_reg <= pixel_address;
        end
        if (r2)
        begin
            addr2_reg <= addr1_reg;
        end
        if (r3)
        begin
            addr3_reg <= addr2_reg;
        end
        if (r4)
        begin
            addr4_reg <= addr3_reg;
            pixel_reg <= packed_next;
        end
    end

    fpab_channel_mix u_mix_r (
        .clk   (clk),
        .en    (stage_en),
        .src   (src_reg.r),
        .dst   (dst_reg.r),
        .alpha (src_reg.a),
        .mixed (mixed.r)
    );

    fpab_channel_mix u_mix_g (
        .clk   (clk),
        .en    (stage_en),
        .src   (src_reg.g),
        .dst   (dst_reg.g),
        .alpha (src_reg.a),
        .mixed (mixed.g)
    );

    fpab_channel_mix u_mix_b (
        .clk   (clk),
        .en    (stage_en),
        .src   (src_reg.b),
        .dst   (dst_reg.b),
        .alpha (src_reg.a),
        .mixed (mixed.b)
    );

    // a + da*(255-a)/255 equals the mix with an opaque source
    fpab_channel_mix u_mix_a (
        .clk   (clk),
        .en    (stage_en),
        .src   (ALPHA_OPAQUE),
        .dst   (dst_reg.a),
        .alpha (src_reg.a),
        .mixed (mixed.a)
    );

    fpab_pack u_pack (
        .fmt   (pixel_mode_reg),
        .color (mixed),
        .word  (packed_next)
    );

    assign write_valid   = v4_reg;
    assign write_address = addr4_reg;
    assign new_pixel     = pixel_reg;

    a_transparent_dropped: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pixel_accept && src_alpha == 8'd0) |=> !v1_reg
    ) else $error("transparent pixel entered the pipeline");

    a_visible_taken: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pixel_accept && src_alpha != 8'd0) |=> v1_reg
    ) else $error("accepted pixel lost at entry stage");

    a_full_stalls_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && write_stall) |-> pixel_stall
    ) else $error("input taken while pipeline full and blocked");

    a_short_format_upper_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (write_valid && pixel_mode_reg != FMT_RGBA8888) |-> (new_pixel[31:16] == 16'd0)
    ) else $error("upper half set in a 16-bit format");

endmodule
